[design/cam_pkg.sv]
// Shared constants, widths and types for the channel magnitude moving-average core.
`timescale 1ns / 1ps
package cam_pkg;

    localparam int WINDOW_MAX   = 16;
    localparam int NUM_SENSORS  = 4;
    localparam int AXES         = 3;
    localparam int CHANNELS     = NUM_SENSORS * AXES;
    localparam int WINDOW_RESET = 10;
    localparam int WINDOW_RESET_EFF = (WINDOW_RESET > WINDOW_MAX) ? WINDOW_MAX : WINDOW_RESET;

    localparam int SAMPLE_W   = 16;
    localparam int MAG_W      = 15;
    localparam int MAG_MAX    = 32767;
    localparam int CFG_W      = 5;
    localparam int SENSOR_W   = 2;
    localparam int AXIS_W     = 2;
    localparam int FILL_OUT_W = 5;

    localparam int POS_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int FILL_W  = $clog2(WINDOW_MAX + 1);
    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ADDR_W  = $clog2(CHANNELS * WINDOW_MAX);
    localparam int TOTAL_W = MAG_W + $clog2(WINDOW_MAX);

    localparam int DIV_STEPS  = 4;
    localparam int DIV_CYCLES = (TOTAL_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DIV_W      = DIV_CYCLES * DIV_STEPS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = SENSOR_W + AXIS_W;
    localparam int M_TDATA_W = 24;
    localparam int M_PAD_W   = M_TDATA_W - MAG_W - FILL_OUT_W;

    localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_HOLD
    } core_state_t;

endpackage

[design/cam_divider.sv]
// Iterative restoring divider that retires four quotient bits per cycle.
`timescale 1ns / 1ps
module cam_divider
    import cam_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [TOTAL_W-1:0] dividend,
    input  logic [FILL_W-1:0]  divisor,
    output logic               busy,
    output logic [MAG_W-1:0]   quotient
);

    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [FILL_W-1:0]    rem_reg, rem_next;
    logic [FILL_W-1:0]    div_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic [FILL_W:0]      trial;

    always_comb begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        trial    = '0;
        for (int i = 0; i < DIV_STEPS; i++) begin
            trial    = {rem_next, quo_next[DIV_W-1]};
            quo_next = {quo_next[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg}) begin
                rem_next    = FILL_W'(trial - {1'b0, div_reg});
                quo_next[0] = 1'b1;
            end else begin
                rem_next = FILL_W'(trial);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(DIV_CYCLES);
        end else if (busy_reg) begin
            cnt_reg  <= cnt_reg - DIV_CNT_W'(1);
            busy_reg <= (cnt_reg != DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= DIV_W'(dividend);
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = MAG_W'(quo_reg);

endmodule

[design/channel_abs_moving_average_core.sv]
// Top level of the per-channel magnitude moving-average core.
// Each accepted sample belongs to one of twelve channels (four sensors by three axes). Its
// magnitude is written into that channel's ring in a single-port sample memory, the channel's
// running total and fill count are updated, and one result with the truncated mean and the
// fill count follows. A sample with axis 3 or an unknown sensor is consumed and gives no
// result, and the core stays ready for the next sample. For a valid sample, the memory read
// of the slot being replaced happens at the transfer itself, then come the update and the
// write-back, then the divider, which retires four quotient bits per cycle, and last the
// load of the output register. The core takes no new sample until that load, so it never
// works on two samples at once and results come out in the order of their samples. A
// result that is still waiting when the next one is ready holds the core, and its input,
// until the waiting result is taken. A write on the configuration channel sets the window
// length (0 acts as 1, values above 16 act as 16) and empties every channel's window; it must
// be issued only while the core is idle. No clearing pass is needed after reset.
`timescale 1ns / 1ps
module channel_abs_moving_average_core
    import cam_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data,      // window_length
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,       // sample_value[15:0]
    input  logic [S_TUSER_W-1:0] s_tuser,       // sensor_index[1:0], axis_select[3:2]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata        // average_magnitude[14:0], fill_count[19:15], zero
);

    core_state_t state_reg, state_next;

    logic [MAG_W-1:0] sample_store_mem [CHANNELS*WINDOW_MAX];
    logic [MAG_W-1:0] rd_data_reg;

    logic [POS_W-1:0]   wpos_reg  [CHANNELS];
    logic [FILL_W-1:0]  fill_reg  [CHANNELS];
    logic [TOTAL_W-1:0] total_reg [CHANNELS];

    logic [FILL_W-1:0]  win_reg;
    logic [FILL_W-1:0]  win_cfg;

    logic [CH_W-1:0]    ch_reg;
    logic [ADDR_W-1:0]  slot_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [MAG_W-1:0]   mag_reg;
    logic [FILL_W-1:0]  cur_fill_reg;
    logic [TOTAL_W-1:0] cur_total_reg;
    logic [FILL_W-1:0]  fill_new_reg;

    logic                  m_tvalid_reg;
    logic [MAG_W-1:0]      m_avg_reg;
    logic [FILL_OUT_W-1:0] m_fill_reg;

    logic [SENSOR_W-1:0]  in_sensor;
    logic [AXIS_W-1:0]    in_axis;
    logic                 in_known;
    logic [CH_W-1:0]      in_ch;
    logic [MAG_W-1:0]     in_mag;
    logic [SAMPLE_W-1:0]  in_neg;
    logic [POS_W-1:0]     in_pos;
    logic [ADDR_W-1:0]    in_slot;

    logic                 in_xfer;
    logic                 cfg_xfer;
    logic                 mem_re;
    logic                 upd;
    logic                 out_free;
    logic                 out_load;

    logic                 full;
    logic [FILL_W-1:0]    fill_upd;
    logic [TOTAL_W-1:0]   total_upd;
    logic [FILL_W-1:0]    pos_inc;
    logic [POS_W-1:0]     pos_upd;

    logic                 div_busy;
    logic [MAG_W-1:0]     div_quotient;

    assign in_sensor = s_tuser[SENSOR_W-1:0];
    assign in_axis   = s_tuser[S_TUSER_W-1:SENSOR_W];
    assign in_known  = (in_axis != AXIS_NONE) && (32'(in_sensor) < NUM_SENSORS);
    assign in_ch     = CH_W'(CH_W'(in_sensor) * CH_W'(AXES) + CH_W'(in_axis));
    assign in_neg    = SAMPLE_W'(~s_tdata + SAMPLE_W'(1));

    always_comb begin
        if (!s_tdata[SAMPLE_W-1]) begin
            in_mag = MAG_W'(s_tdata);
        end else if (in_neg[SAMPLE_W-1]) begin
            in_mag = MAG_W'(MAG_MAX);
        end else begin
            in_mag = MAG_W'(in_neg);
        end
    end

    always_comb begin
        in_pos = wpos_reg[in_ch];
        if (FILL_W'(in_pos) >= win_reg) begin
            in_pos = '0;
        end
    end

    assign in_slot = ADDR_W'(ADDR_W'(in_ch) * ADDR_W'(WINDOW_MAX) + ADDR_W'(in_pos));

    always_comb begin
        if (cfg_data == '0) begin
            win_cfg = FILL_W'(1);
        end else if (32'(cfg_data) > WINDOW_MAX) begin
            win_cfg = FILL_W'(WINDOW_MAX);
        end else begin
            win_cfg = FILL_W'(cfg_data);
        end
    end

    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign full     = (cur_fill_reg >= win_reg);
    assign fill_upd = full ? win_reg : FILL_W'(cur_fill_reg + FILL_W'(1));
    assign total_upd = full
        ? TOTAL_W'(cur_total_reg - TOTAL_W'(rd_data_reg) + TOTAL_W'(mag_reg))
        : TOTAL_W'(cur_total_reg + TOTAL_W'(mag_reg));
    assign pos_inc  = FILL_W'(FILL_W'(pos_reg) + FILL_W'(1));
    assign pos_upd  = (pos_inc >= win_reg) ? '0 : POS_W'(pos_inc);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer && in_known) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (!div_busy) begin
                    state_next = out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        upd      = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_UPDATE: begin
                upd = 1'b1;
            end
            ST_DIVIDE: begin
                out_load = !div_busy && out_free;
            end
            ST_HOLD: begin
                out_load = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign mem_re = in_xfer && in_known;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (upd) begin
            sample_store_mem[slot_reg] <= mag_reg;
        end
        if (mem_re) begin
            rd_data_reg <= sample_store_mem[in_slot];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= FILL_W'(WINDOW_RESET_EFF);
        end else if (cfg_xfer) begin
            win_reg <= win_cfg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_xfer) begin
            for (int c = 0; c < CHANNELS; c++) begin
                wpos_reg[c]  <= '0;
                fill_reg[c]  <= '0;
                total_reg[c] <= '0;
            end
        end else if (upd) begin
            wpos_reg[ch_reg]  <= pos_upd;
            fill_reg[ch_reg]  <= fill_upd;
            total_reg[ch_reg] <= total_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            ch_reg        <= in_ch;
            slot_reg      <= in_slot;
            pos_reg       <= in_pos;
            mag_reg       <= in_mag;
            cur_fill_reg  <= fill_reg[in_ch];
            cur_total_reg <= total_reg[in_ch];
        end
        if (upd) begin
            fill_new_reg <= fill_upd;
        end
    end

    cam_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (upd),
        .dividend (total_upd),
        .divisor  (fill_upd),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_avg_reg  <= div_quotient;
            m_fill_reg <= FILL_OUT_W'(fill_new_reg);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {M_PAD_W'(0), m_fill_reg, m_avg_reg};

endmodule

[design/cam_checker.sv]
// Port-level checker for the moving-average core and its bind to the top level.
`timescale 1ns / 1ps
module cam_checker
    import cam_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TUSER_W-1:0] s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // A stalled result transfer keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Every delivered result covers at least one sample and has clean padding.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[MAG_W+FILL_OUT_W-1:MAG_W] != '0)
                     && (m_tdata[M_TDATA_W-1:MAG_W+FILL_OUT_W] == '0))
        else $error("result with empty window or nonzero padding");

    // A sample on a real channel holds off the next one while it is processed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[S_TUSER_W-1:SENSOR_W] != AXIS_NONE)
            && (32'(s_tuser[SENSOR_W-1:0]) < NUM_SENSORS)
        |=> !s_tready ##1 !s_tready)
        else $error("input taken during update");

    // No result can appear in the cycle right after a sample transfer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared too early");

endmodule

bind channel_abs_moving_average_core cam_checker u_cam_checker (.*);

[test/tb.sv]
// Self-checking testbench for the channel magnitude moving-average core.
`timescale 1ns / 1ps
module tb
    import cam_pkg::*;
();

    typedef struct {
        logic [SENSOR_W-1:0] sensor;
        logic [AXIS_W-1:0]   axis;
        logic [SAMPLE_W-1:0] sample;
    } sample_item_t;

    typedef struct {
        logic [MAG_W-1:0]      avg;
        logic [FILL_OUT_W-1:0] fill;
    } mean_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    sample_item_t feed_q[$];
    mean_result_t pending_means[$];
    int           samples_queued = 0;
    int           samples_taken = 0;
    int           failures = 0;
    bit           s_moved = 1'b0;
    bit           quiet = 1'b0;
    bit           long_hold_req = 1'b0;
    bit           held_once = 1'b0;
    int           send_gap = 0;
    int           stall_left = 0;

    // Predictor state, one window per sensor and axis.
    logic [MAG_W-1:0]   ring_mag[CHANNELS][WINDOW_MAX];
    logic [POS_W-1:0]   ring_pos[CHANNELS];
    logic [FILL_W-1:0]  ring_fill[CHANNELS];
    logic [TOTAL_W-1:0] ring_total[CHANNELS];
    logic [CFG_W-1:0]   window_reg = CFG_W'(WINDOW_RESET);

    channel_abs_moving_average_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("channel_abs_moving_average_core verification failed");
        $finish;
    end

    function automatic void empty_windows();
        for (int c = 0; c < CHANNELS; c++) begin
            ring_pos[c]   = '0;
            ring_fill[c]  = '0;
            ring_total[c] = '0;
        end
    endfunction

    function automatic int unsigned active_window();
        if (window_reg == 0) return 1;
        if (window_reg > WINDOW_MAX) return WINDOW_MAX;
        return 32'(window_reg);
    endfunction

    // Returns 1 when the sample belongs to a real channel and yields a mean.
    function automatic bit absorb_sample(input sample_item_t it, output mean_result_t res);
        int unsigned w, ch, pos, fill;
        logic [16:0] neg;
        logic [MAG_W-1:0] mag;
        if (it.axis == AXIS_NONE || it.sensor >= NUM_SENSORS) return 1'b0;
        if (it.sample[SAMPLE_W-1]) begin
            neg = 17'h10000 - {1'b0, it.sample};
            mag = (neg > MAG_MAX) ? MAG_W'(MAG_MAX) : neg[MAG_W-1:0];
        end else begin
            mag = it.sample[MAG_W-1:0];
        end
        w = active_window();
        ch = it.sensor * AXES + it.axis;
        pos = 32'(ring_pos[ch]);
        if (pos >= w) pos = 0;
        fill = 32'(ring_fill[ch]);
        if (fill >= w) begin
            ring_total[ch] = ring_total[ch] - ring_mag[ch][pos];
            fill = w;
        end else begin
            fill = fill + 1;
        end
        ring_mag[ch][pos] = mag;
        ring_total[ch] = ring_total[ch] + mag;
        ring_fill[ch] = fill[FILL_W-1:0];
        pos = pos + 1;
        if (pos >= w) pos = 0;
        ring_pos[ch] = pos[POS_W-1:0];
        res.avg  = MAG_W'(ring_total[ch] / fill);
        res.fill = FILL_OUT_W'(fill);
        return 1'b1;
    endfunction

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_moved) begin
            s_tvalid <= 1'b1;
        end else if (send_gap > 0) begin
            send_gap = send_gap - 1;
            s_tvalid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(0, 15);
            s_tvalid <= 1'b0;
        end else if (feed_q.size() > 0) begin
            sample_item_t it;
            it = feed_q.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= it.sample;
            s_tuser  <= {it.axis, it.sensor};
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (long_hold_req && !held_once) begin
            held_once = 1'b1;
            stall_left = 400;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 15);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_moved <= 1'b0;
            window_reg = CFG_W'(WINDOW_RESET);
            empty_windows();
        end else begin
            s_moved <= s_tvalid && s_tready;
            if (cfg_valid && cfg_ready) begin
                window_reg = cfg_data;
                empty_windows();
            end
            if (s_tvalid && s_tready) begin
                sample_item_t it;
                mean_result_t res;
                it.sample = s_tdata;
                it.sensor = s_tuser[SENSOR_W-1:0];
                it.axis   = s_tuser[SENSOR_W +: AXIS_W];
                samples_taken = samples_taken + 1;
                if (absorb_sample(it, res)) pending_means.push_back(res);
            end
            if (m_tvalid && m_tready) begin
                mean_result_t want;
                if (pending_means.size() == 0) begin
                    failures = failures + 1;
                    $display("%0t: unexpected result, got avg %0d fill %0d", $time,
                             m_tdata[MAG_W-1:0], m_tdata[MAG_W +: FILL_OUT_W]);
                end else begin
                    want = pending_means.pop_front();
                    if (m_tdata[MAG_W-1:0] !== want.avg
                            || m_tdata[MAG_W +: FILL_OUT_W] !== want.fill) begin
                        failures = failures + 1;
                        $display("%0t: expected avg %0d fill %0d, got avg %0d fill %0d",
                                 $time, want.avg, want.fill, m_tdata[MAG_W-1:0],
                                 m_tdata[MAG_W +: FILL_OUT_W]);
                    end
                end
            end
        end
    end

    task automatic offer(input int sensor, input int axis, input logic [SAMPLE_W-1:0] v);
        sample_item_t it;
        it.sensor = SENSOR_W'(sensor);
        it.axis   = AXIS_W'(axis);
        it.sample = v;
        feed_q.push_back(it);
        samples_queued = samples_queued + 1;
    endtask

    task automatic settle();
        while (samples_taken != samples_queued || pending_means.size() != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic set_window(input logic [CFG_W-1:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Each sample of a batch goes to one chosen channel with even odds, so that large windows fill and wrap.
    task automatic offer_batch(input int count);
        int hot_sensor, hot_axis, sensor, axis, pick;
        logic [SAMPLE_W-1:0] v;
        hot_sensor = $urandom_range(0, NUM_SENSORS - 1);
        hot_axis = $urandom_range(0, AXES - 1);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 1) == 0) begin
                sensor = hot_sensor;
                axis = hot_axis;
            end else begin
                sensor = $urandom_range(0, 3);
                axis = $urandom_range(0, AXES - 1);
            end
            if ($urandom_range(0, 15) == 0) axis = int'(AXIS_NONE);
            pick = $urandom_range(0, 9);
            case (pick)
                0: v = 16'h8000;
                1: v = 16'h7FFF;
                2: v = 16'h8001;
                3: v = SAMPLE_W'($urandom_range(0, 3) - 2);
                default: v = SAMPLE_W'($urandom);
            endcase
            offer(sensor, axis, v);
        end
    endtask

    initial begin
        logic [SAMPLE_W-1:0] corner_vals[11];
        logic [CFG_W-1:0] windows[9];
        corner_vals = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h8001,
                        16'h5555, 16'hAAAA, 16'd100, 16'hFF9C, 16'd7};
        windows = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd7, 5'd0, 5'd15, 5'd16};
        windows[6] = CFG_W'($urandom_range(0, 31));
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // The reset window of ten wraps on the first channel after ten samples.
        foreach (corner_vals[i]) offer(0, 0, corner_vals[i]);
        offer(0, int'(AXIS_NONE), 16'h1234);
        offer(3, int'(AXIS_NONE), 16'hFFFF);
        for (int s = 0; s < NUM_SENSORS; s++)
            for (int a = 0; a < AXES; a++)
                offer(s, a, (a == 1) ? 16'h8000 : 16'(s * 1000 + a));
        settle();

        foreach (windows[i]) begin
            if (i == 8) quiet = 1'b1;
            set_window(windows[i]);
            offer_batch(120);
            if (i == 2) long_hold_req = 1'b1;
            settle();
        end

        repeat (20) @(posedge aclk);
        if (failures == 0 && pending_means.size() == 0) begin
            $display("channel_abs_moving_average_core verification clean");
        end else begin
            $display("channel_abs_moving_average_core verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
design/cam_pkg.sv
design/cam_divider.sv
design/channel_abs_moving_average_core.sv
design/cam_checker.sv
test/tb.sv
